// ----- src/chp_pkg.sv -----
package chp_pkg;

   localparam int DEPTH       = 4096;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int CNT_W       = ADDR_W + 1;
   localparam int LENGTH_BITS = 16;
   localparam int LEN_W       = 16;
   localparam int POS_W       = 29;
   localparam int LIMIT_W     = 24;
   localparam int VAL_W       = 64;
   localparam int COST_W      = 62;
   localparam int MUL_W       = 33;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int ACC_W       = 96;
   localparam int RAM_W       = POS_W + VAL_W;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [POS_W-1:0] POS_MAX = '1;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   localparam logic CSR_IDX_GROUP_LIMIT = 1'b0;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MUL_T,
      ST_MUL_E,
      ST_MUL_S,
      ST_SAVE_SS,
      ST_RD_CUR,
      ST_MUL_CUR,
      ST_SUM_CUR,
      ST_RD_NXT,
      ST_MUL_NXT,
      ST_SUM_NXT,
      ST_ADV,
      ST_FIN,
      ST_Y,
      ST_RD_A,
      ST_RD_B,
      ST_DIFF,
      ST_P1L,
      ST_P1H,
      ST_P2L,
      ST_P2H,
      ST_P2S,
      ST_P2N,
      ST_CMP,
      ST_WRITE,
      ST_DONE
   } state_type;

   typedef enum logic [4:0] {
      OP_NOP,
      OP_MUL_T,
      OP_MUL_E,
      OP_MUL_S,
      OP_SAVE_SS,
      OP_RD_CUR,
      OP_MUL_X,
      OP_SUM_CUR,
      OP_RD_NXT,
      OP_SUM_NXT,
      OP_ADV,
      OP_FIN,
      OP_Y,
      OP_RD_A,
      OP_RD_B,
      OP_DIFF,
      OP_P1L,
      OP_P1H,
      OP_P2L,
      OP_P2H,
      OP_P2S,
      OP_P2N,
      OP_POP,
      OP_WRITE
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      in_load;
      logic      out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic start;
      logic cnt_gt0;
      logic cnt_gt1;
      logic cnt_gt2;
      logic has_next;
      logic has_next2;
      logic full;
      logic better;
      logic pop;
   } dp_status_type;

endpackage

// ----- src/convex_hull_packing_cost_dp.sv -----
// Per item: the cost multiplies, then, unless the sequence is new, a best-pointer search
// over the hull, then hull checks and a hull write while the store is not full.
// One item in work at a time; the next transfer is taken in the cycle after the result
// loads. The single 33x33 multiplier is shared by cost, candidate and cross-product terms,
// and the hull RAM is one-read.
// Reset (sync, active high) clears position, counts, pointer, flags, limit and rsp valid.
module convex_hull_packing_cost_dp
   import chp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,   // [15:0] item_length
   input  logic                  req_tuser,   // [0] first_item
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [63:0]           rsp_tdata,   // [61:0] prefix_cost, [63:62] zero
   output logic                  rsp_tuser,   // [0] overflow
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [LIMIT_W-1:0] group_limit_ff;
   dp_cmd_type         cmd;
   dp_status_type      status;
   logic [COST_W-1:0]  prefix_cost;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         group_limit_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && csr_paddr[2] == CSR_IDX_GROUP_LIMIT) begin
         group_limit_ff <= csr_pwdata[LIMIT_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_IDX_GROUP_LIMIT)
                       ? {{(CSR_DATA_W-LIMIT_W){1'b0}}, group_limit_ff} : '0;

   chp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   chp_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .group_limit (group_limit_ff),
      .item_length (req_tdata),
      .first_item  (req_tuser),
      .prefix_cost (prefix_cost),
      .overflow    (rsp_tuser)
   );

   assign rsp_tdata = {2'b00, prefix_cost};

endmodule

// ----- src/chp_ram.sv -----
module chp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/chp_ctrl.sv -----
module chp_ctrl
   import chp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_NOP;
      cmd.in_load  = 1'b0;
      cmd.out_load = 1'b0;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.in_load = 1'b1;
               state_in    = ST_MUL_T;
            end
         end
         ST_MUL_T: begin
            cmd.op   = OP_MUL_T;
            state_in = ST_MUL_E;
         end
         ST_MUL_E: begin
            cmd.op   = OP_MUL_E;
            state_in = ST_MUL_S;
         end
         ST_MUL_S: begin
            cmd.op   = OP_MUL_S;
            state_in = ST_SAVE_SS;
         end
         ST_SAVE_SS: begin
            cmd.op = OP_SAVE_SS;
            if (!status.start && status.cnt_gt0) begin
               state_in = ST_RD_CUR;
            end else if (status.full) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_Y;
            end
         end
         ST_RD_CUR: begin
            cmd.op   = OP_RD_CUR;
            state_in = ST_MUL_CUR;
         end
         ST_MUL_CUR: begin
            cmd.op   = OP_MUL_X;
            state_in = ST_SUM_CUR;
         end
         ST_SUM_CUR: begin
            cmd.op   = OP_SUM_CUR;
            state_in = status.has_next ? ST_RD_NXT : ST_FIN;
         end
         ST_RD_NXT: begin
            cmd.op   = OP_RD_NXT;
            state_in = ST_MUL_NXT;
         end
         ST_MUL_NXT: begin
            cmd.op   = OP_MUL_X;
            state_in = ST_SUM_NXT;
         end
         ST_SUM_NXT: begin
            cmd.op   = OP_SUM_NXT;
            state_in = ST_ADV;
         end
         ST_ADV: begin
            cmd.op   = OP_ADV;
            state_in = (status.better && status.has_next2) ? ST_RD_NXT : ST_FIN;
         end
         ST_FIN: begin
            cmd.op   = OP_FIN;
            state_in = status.full ? ST_DONE : ST_Y;
         end
         ST_Y: begin
            cmd.op   = OP_Y;
            state_in = status.cnt_gt1 ? ST_RD_A : ST_WRITE;
         end
         ST_RD_A: begin
            cmd.op   = OP_RD_A;
            state_in = ST_RD_B;
         end
         ST_RD_B: begin
            cmd.op   = OP_RD_B;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.op   = OP_DIFF;
            state_in = ST_P1L;
         end
         ST_P1L: begin
            cmd.op   = OP_P1L;
            state_in = ST_P1H;
         end
         ST_P1H: begin
            cmd.op   = OP_P1H;
            state_in = ST_P2L;
         end
         ST_P2L: begin
            cmd.op   = OP_P2L;
            state_in = ST_P2H;
         end
         ST_P2H: begin
            cmd.op   = OP_P2H;
            state_in = ST_P2S;
         end
         ST_P2S: begin
            cmd.op   = OP_P2S;
            state_in = ST_P2N;
         end
         ST_P2N: begin
            cmd.op   = OP_P2N;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (status.pop) begin
               cmd.op   = OP_POP;
               state_in = status.cnt_gt2 ? ST_RD_A : ST_WRITE;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.op   = OP_WRITE;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- src/chp_datapath.sv -----
module chp_datapath
   import chp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   output dp_status_type      status,
   input  logic [LIMIT_W-1:0] group_limit,
   input  logic [LEN_W-1:0]   item_length,
   input  logic               first_item,
   output logic [COST_W-1:0]  prefix_cost,
   output logic               overflow
);

   logic [POS_W-1:0]  pos_ff;
   logic [CNT_W-1:0]  idx_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [ADDR_W-1:0] bp_ff;
   logic              sat_ff;
   logic              depth_ovf_ff;
   logic              start_ff;

   logic [MUL_W-1:0]         e_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [VAL_W-1:0]  cost_ff, ee_ff, ss_ff, y_ff, cy_ff, cur_ff, nxt_ff;
   logic [VAL_W-1:0]  ya_ff, m1_ff, m3_ff;
   logic [POS_W-1:0]  xa_ff, m2_ff, m4_ff;
   logic              neg1_ff, neg2_ff;
   logic [ACC_W-1:0]  acc_ff, p1_ff, p2_ff;
   logic [COST_W-1:0] out_cost_ff;
   logic              out_ovf_ff;

   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic [ADDR_W-1:0]       rd_addr;
   logic [RAM_W-1:0]        rd_data;
   logic [POS_W-1:0]        ram_x;
   logic [VAL_W-1:0]        ram_y;
   logic [MUL_W-1:0]        t_val, e_val;
   logic [VAL_W-1:0]        cand_sum;
   logic [ACC_W-1:0]        prod_ext, prod_shift;
   logic [LEN_W-1:0]        len_c;
   logic [POS_W:0]          next_pos;
   logic                    start_now;
   logic [CNT_W-1:0]        bp_ext;

   assign ram_x      = rd_data[RAM_W-1:VAL_W];
   assign ram_y      = rd_data[VAL_W-1:0];
   assign t_val      = {{(MUL_W-POS_W){1'b0}}, pos_ff} - {{(MUL_W-LIMIT_W){1'b0}}, group_limit};
   assign e_val      = {{(MUL_W-LIMIT_W){1'b0}}, group_limit} + MUL_W'(1)
                       - {{(MUL_W-POS_W){1'b0}}, pos_ff};
   assign cand_sum   = cy_ff + {prod_ff[VAL_W-2:0], 1'b0} + ee_ff;
   assign prod_ext   = {{(ACC_W-PROD_W){1'b0}}, prod_ff};
   assign prod_shift = {prod_ext[ACC_W-33:0], 32'b0};
   assign len_c      = item_length & LEN_W'((1 << LENGTH_BITS) - 1);
   assign next_pos   = {1'b0, pos_ff} + (POS_W+1)'(len_c) + (POS_W+1)'(1);
   assign start_now  = first_item || (idx_ff == '0);
   assign bp_ext     = {1'b0, bp_ff};

   assign status.start     = start_ff;
   assign status.cnt_gt0   = cnt_ff > CNT_W'(0);
   assign status.cnt_gt1   = cnt_ff > CNT_W'(1);
   assign status.cnt_gt2   = cnt_ff > CNT_W'(2);
   assign status.has_next  = (bp_ext + CNT_W'(1)) < cnt_ff;
   assign status.has_next2 = (bp_ext + CNT_W'(2)) < cnt_ff;
   assign status.full      = idx_ff >= DEPTH_CNT;
   assign status.better    = nxt_ff < cur_ff;
   assign status.pop       = $signed(p1_ff) >= $signed(p2_ff);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         OP_MUL_T: begin
            mul_a = t_val;
            mul_b = t_val;
         end
         OP_MUL_E: begin
            mul_a = e_val;
            mul_b = e_val;
         end
         OP_MUL_S: begin
            mul_a = {{(MUL_W-POS_W){1'b0}}, pos_ff};
            mul_b = {{(MUL_W-POS_W){1'b0}}, pos_ff};
         end
         OP_MUL_X: begin
            mul_a = {{(MUL_W-POS_W){1'b0}}, ram_x};
            mul_b = e_ff;
         end
         OP_P1L: begin
            mul_a = {1'b0, m1_ff[31:0]};
            mul_b = {{(MUL_W-POS_W){1'b0}}, m2_ff};
         end
         OP_P1H: begin
            mul_a = {1'b0, m1_ff[63:32]};
            mul_b = {{(MUL_W-POS_W){1'b0}}, m2_ff};
         end
         OP_P2L: begin
            mul_a = {1'b0, m3_ff[31:0]};
            mul_b = {{(MUL_W-POS_W){1'b0}}, m4_ff};
         end
         OP_P2H: begin
            mul_a = {1'b0, m3_ff[63:32]};
            mul_b = {{(MUL_W-POS_W){1'b0}}, m4_ff};
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      unique case (cmd.op)
         OP_RD_NXT: rd_addr = bp_ff + ADDR_W'(1);
         OP_RD_A:   rd_addr = ADDR_W'(cnt_ff - CNT_W'(2));
         OP_RD_B:   rd_addr = ADDR_W'(cnt_ff - CNT_W'(1));
         default:   rd_addr = bp_ff;
      endcase
   end

   chp_ram #(
      .WIDTH (RAM_W),
      .DEPTH (DEPTH)
   ) u_hull_ram (
      .clock   (clock),
      .wr_en   (cmd.op == OP_WRITE && !status.full),
      .wr_addr (cnt_ff[ADDR_W-1:0]),
      .wr_data ({pos_ff, y_ff}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         bp_ff        <= '0;
         sat_ff       <= 1'b0;
         depth_ovf_ff <= 1'b0;
         start_ff     <= 1'b0;
      end else begin
         if (cmd.in_load) begin
            start_ff <= start_now;
            if (start_now) begin
               pos_ff       <= POS_W'(len_c);
               cnt_ff       <= '0;
               bp_ff        <= '0;
               idx_ff       <= '0;
               sat_ff       <= 1'b0;
               depth_ovf_ff <= 1'b0;
            end else begin
               depth_ovf_ff <= idx_ff >= DEPTH_CNT;
               if (next_pos > {1'b0, POS_MAX}) begin
                  pos_ff <= POS_MAX;
                  sat_ff <= 1'b1;
               end else begin
                  pos_ff <= next_pos[POS_W-1:0];
               end
            end
         end
         unique case (cmd.op)
            OP_MUL_T: begin
               if (!start_ff && status.cnt_gt0 && bp_ext >= cnt_ff) begin
                  bp_ff <= ADDR_W'(cnt_ff - CNT_W'(1));
               end
            end
            OP_ADV: begin
               if (status.better) begin
                  bp_ff <= bp_ff + ADDR_W'(1);
               end
            end
            OP_POP: begin
               cnt_ff <= cnt_ff - CNT_W'(1);
               if (bp_ext == cnt_ff - CNT_W'(1) && bp_ff != '0) begin
                  bp_ff <= bp_ff - ADDR_W'(1);
               end
            end
            OP_WRITE: begin
               if (!status.full) begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
                  idx_ff <= idx_ff + CNT_W'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (cmd.out_load) begin
         out_cost_ff <= cost_ff[COST_W-1:0];
         out_ovf_ff  <= depth_ovf_ff || sat_ff;
      end
      unique case (cmd.op)
         OP_MUL_E: begin
            cost_ff <= prod_ff[VAL_W-1:0];
            e_ff    <= e_val;
         end
         OP_MUL_S:   ee_ff  <= prod_ff[VAL_W-1:0];
         OP_SAVE_SS: ss_ff  <= prod_ff[VAL_W-1:0];
         OP_MUL_X:   cy_ff  <= ram_y;
         OP_SUM_CUR: cur_ff <= cand_sum;
         OP_SUM_NXT: nxt_ff <= cand_sum;
         OP_ADV: begin
            if (status.better) begin
               cur_ff <= nxt_ff;
            end
         end
         OP_FIN: begin
            if (cur_ff < cost_ff) begin
               cost_ff <= cur_ff;
            end
         end
         OP_Y: y_ff <= cost_ff + ss_ff;
         OP_RD_B: begin
            xa_ff <= ram_x;
            ya_ff <= ram_y;
         end
         OP_DIFF: begin
            neg1_ff <= (ya_ff < ram_y) ^ (ram_x < pos_ff);
            neg2_ff <= (ram_y < y_ff) ^ (xa_ff < ram_x);
            m1_ff   <= (ya_ff < ram_y) ? ram_y - ya_ff : ya_ff - ram_y;
            m2_ff   <= (ram_x < pos_ff) ? pos_ff - ram_x : ram_x - pos_ff;
            m3_ff   <= (ram_y < y_ff) ? y_ff - ram_y : ram_y - y_ff;
            m4_ff   <= (xa_ff < ram_x) ? ram_x - xa_ff : xa_ff - ram_x;
         end
         OP_P1H: acc_ff <= prod_ext;
         OP_P2L: p1_ff  <= acc_ff + prod_shift;
         OP_P2H: begin
            acc_ff <= prod_ext;
            if (neg1_ff) begin
               p1_ff <= ~p1_ff + ACC_W'(1);
            end
         end
         OP_P2S: p2_ff <= acc_ff + prod_shift;
         OP_P2N: begin
            if (neg2_ff) begin
               p2_ff <= ~p2_ff + ACC_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   assign prefix_cost = out_cost_ff;
   assign overflow    = out_ovf_ff;

endmodule

// ----- tb/tb_convex_hull_packing_cost_dp.sv -----
`timescale 1ns / 100ps

module tb_convex_hull_packing_cost_dp;
   import chp_pkg::*;

   localparam int WATCHDOG_LIMIT = 200000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [15:0]           req_tdata = '0;    // [15:0] item_length
   logic                  req_tuser = 1'b0;  // [0] first_item
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [63:0]           rsp_tdata;         // [61:0] prefix_cost, [63:62] zero
   logic                  rsp_tuser;         // [0] overflow
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   convex_hull_packing_cost_dp dut (.*);

   always #10 clock = ~clock;

   // shadow of the grouping state
   logic [63:0] group_lim = '0;
   logic [63:0] run_pos = '0;
   int unsigned seq_count = 0;
   logic [63:0] pt_x [DEPTH];
   logic [63:0] pt_y [DEPTH];
   int unsigned pt_count = 0;
   int unsigned best_pt = 0;
   bit          pos_sat = 1'b0;

   logic [61:0] cost_q [$];
   bit          ovf_q [$];
   bit          failed = 1'b0;
   int          send_idle = 0;
   int          recv_idle = 0;
   int          quiet_cycles = 0;

   function automatic logic [63:0] line_value(int unsigned k, logic [63:0] s,
                                              logic [63:0] lp);
      logic [63:0] d;
      d = s - lp;
      return pt_y[k] + 64'd2 * pt_x[k] * (lp - s) + d * d;
   endfunction

   // signed product with the sign bit flipped so unsigned compare orders it
   function automatic logic [127:0] ordered_prod(bit neg, logic [63:0] a,
                                                 logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      if (neg) p = -p;
      p[127] = ~p[127];
      return p;
   endfunction

   task automatic predict_cost(input logic [15:0] len, input bit first);
      logic [63:0]  s, lp, t, cost, y, v, np, m1, m2, m3, m4;
      logic [127:0] p1, p2;
      bit           start, n1, n2, n3, n4, stop;
      int unsigned  idx, a, b;
      start = first || seq_count == 0;
      if (start) begin
         run_pos = {48'd0, len};
         pt_count = 0;
         best_pt = 0;
         seq_count = 0;
         pos_sat = 1'b0;
      end else begin
         np = run_pos + len + 64'd1;
         if (np > 64'(POS_MAX)) begin
            np = 64'(POS_MAX);
            pos_sat = 1'b1;
         end
         run_pos = np;
      end
      s = run_pos;
      lp = group_lim + 64'd1;
      idx = seq_count;
      t = s - group_lim;
      cost = t * t;
      if (!start && pt_count > 0) begin
         if (best_pt >= pt_count) best_pt = pt_count - 1;
         while (best_pt + 1 < pt_count &&
                line_value(best_pt + 1, s, lp) < line_value(best_pt, s, lp))
            best_pt++;
         v = line_value(best_pt, s, lp);
         if (v < cost) cost = v;
      end
      if (idx < DEPTH) begin
         y = cost + s * s;
         stop = 1'b0;
         while (pt_count > 1 && !stop) begin
            a = pt_count - 2;
            b = pt_count - 1;
            n1 = pt_y[a] < pt_y[b];
            m1 = n1 ? pt_y[b] - pt_y[a] : pt_y[a] - pt_y[b];
            n2 = pt_x[b] < s;
            m2 = n2 ? s - pt_x[b] : pt_x[b] - s;
            n3 = pt_y[b] < y;
            m3 = n3 ? y - pt_y[b] : pt_y[b] - y;
            n4 = pt_x[a] < pt_x[b];
            m4 = n4 ? pt_x[b] - pt_x[a] : pt_x[a] - pt_x[b];
            p1 = ordered_prod(n1 != n2 && m1 != 0 && m2 != 0, m1, m2);
            p2 = ordered_prod(n3 != n4 && m3 != 0 && m4 != 0, m3, m4);
            if (p1 >= p2) begin
               pt_count--;
               if (best_pt == pt_count && best_pt > 0) best_pt--;
            end else begin
               stop = 1'b1;
            end
         end
         pt_x[pt_count] = s;
         pt_y[pt_count] = y;
         pt_count++;
         seq_count = idx + 1;
      end else begin
         seq_count = DEPTH;
      end
      cost_q.push_back(cost[61:0]);
      ovf_q.push_back(idx >= DEPTH || pos_sat);
   endtask

   always @(negedge clock)
      if (!reset) rsp_tready <= ($urandom_range(99) >= recv_idle);

   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         if (cost_q.size() == 0) begin
            $display("%0t: unexpected result cost=%0d ovf=%0d", $time,
                     rsp_tdata[61:0], rsp_tuser);
            failed = 1'b1;
         end else begin
            if (rsp_tdata !== {2'b00, cost_q[0]}) begin
               $display("%0t: cost expected %0d actual %0d", $time, cost_q[0],
                        rsp_tdata);
               failed = 1'b1;
            end
            if (rsp_tuser !== ovf_q[0]) begin
               $display("%0t: overflow expected %0d actual %0d", $time, ovf_q[0],
                        rsp_tuser);
               failed = 1'b1;
            end
            void'(cost_q.pop_front());
            void'(ovf_q.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("convex_hull_packing_cost_dp: mismatch");
         $finish;
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_item(input logic [15:0] len, input bit first);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= len;
      req_tuser <= first;
      do @(posedge clock); while (!req_tready);
      predict_cost(len, first);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (cost_q.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_limit(input logic [23:0] value);
      drain();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(4 * CSR_IDX_GROUP_LIMIT);
      csr_pwdata <= {8'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      group_lim = {40'd0, value};
   endtask

   task automatic test_directed();
      send_item(16'd5, 1'b0);  // no sequence open yet
      send_item(16'hffff, 1'b0);
      send_item(16'd0, 1'b0);
      send_item(16'd0, 1'b0);
      write_limit(24'hffffff);
      send_item(16'hffff, 1'b1);
      send_item(16'hffff, 1'b0);
      send_item(16'h0000, 1'b0);
      send_item(16'h5555, 1'b0);
      send_item(16'haaaa, 1'b0);
      write_limit(24'd20);
      for (int k = 0; k < 12; k++) send_item(16'($urandom_range(0, 25)), k == 0);
      send_item(16'd3, 1'b1);
      send_item(16'd3, 1'b1);
   endtask

   task automatic test_random(input int items, input int s_idle, input int r_idle);
      int n, mode;
      logic [15:0] len;
      send_idle = s_idle;
      recv_idle = r_idle;
      n = 0;
      while (n < items) begin
         mode = $urandom_range(2);
         for (int k = $urandom_range(1, 30); k > 0 && n < items; k--) begin
            case (mode)
               0: len = 16'($urandom_range(0, 40));
               1: len = 16'($urandom);
               default: len = 16'(group_lim[15:0] + $urandom_range(0, 8));
            endcase
            send_item(len, (k > 0 && n == 0) ? 1'b1 : ($urandom_range(99) < 4));
            n++;
         end
         send_item(16'($urandom), 1'b1);
         n++;
         if ($urandom_range(99) < 5) drain();
      end
   endtask

   // long run of large items in one sequence
   task automatic test_long_sequence();
      send_idle = 0;
      recv_idle = 0;
      write_limit(24'd1000000);
      send_item(16'hffff, 1'b1);
      for (int k = 0; k < 150; k++) send_item(16'($urandom_range(65000, 65535)), 1'b0);
      send_item(16'd7, 1'b1);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      write_limit(24'd100);
      test_random(250, 20, 67);
      write_limit(24'($urandom));
      test_random(250, 67, 20);
      write_limit(24'd0);
      test_random(150, 0, 0);
      test_long_sequence();
      drain();
      if (!failed)
         $display("convex_hull_packing_cost_dp: match");
      else
         $display("convex_hull_packing_cost_dp: mismatch");
      $finish;
   end

endmodule

// ----- sim.f -----
src/chp_pkg.sv
src/chp_ram.sv
src/chp_ctrl.sv
src/chp_datapath.sv
src/convex_hull_packing_cost_dp.sv
tb/tb_convex_hull_packing_cost_dp.sv
